@@ rtl/div3216_pkg.sv @@
// shared types, constants and the restoring step for the 32 by 16 divider
// depends on nothing; used by divide_32_by_16_with_flags
`default_nettype none

package div3216_pkg;

    localparam int DIVIDEND_W      = 32;
    localparam int DIVISOR_W       = 16;
    localparam int QUOT_W          = 16;
    localparam int IN_DATA_W       = 48;
    localparam int IN_USER_W       = 1;
    localparam int OUT_DATA_W      = 32;
    localparam int OUT_USER_W      = 4;
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [QUOT_W-1:0] QUOT_MAX_U   = 16'hFFFF;
    localparam logic [QUOT_W-1:0] QUOT_MAX_NEG = 16'h8000;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef struct packed {
        logic                  op;
        logic                  num_neg;
        logic                  qneg;
        logic                  dbz;
        logic                  ovf;
        logic [DIVIDEND_W-1:0] num;
        logic [QUOT_W-1:0]     rem;
        logic [QUOT_W-1:0]     low;
        logic [DIVISOR_W-1:0]  den;
    } pipe_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t           r;
        logic [QUOT_W:0] part;
        logic [QUOT_W:0] diff;
        r    = p;
        part = {p.rem, p.low[QUOT_W-1]};
        diff = part - {1'b0, p.den};
        if (!diff[QUOT_W])
        begin
            r.rem = diff[QUOT_W-1:0];
            r.low = {p.low[QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = part[QUOT_W-1:0];
            r.low = {p.low[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/divide_32_by_16_with_flags.sv @@
// top level of the pipelined 32 by 16 divider, unsigned and signed, with flags
// depends on div3216_pkg
`default_nettype none

// Takes one transaction per clock while the output is not stalled, in stages:
// one stage forms the operand magnitudes and the early overflow test, four
// stages run four restoring steps each (sixteen quotient bits), and the last
// stage restores the signs, checks the signed range and registers the result.
// Every stage has its own valid bit and ready, so a stalled output only holds
// the stages behind it that are full; empty stages keep taking new work.
module divide_32_by_16_with_flags (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dividend [31:0], divisor [47:32]
    input  wire  [div3216_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation [0]
    input  wire  [div3216_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // packed_result [31:0]
    output logic [div3216_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // overflow [0], negative [1], zero [2], divide_by_zero [3]
    output logic [div3216_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    localparam int NSTG = div3216_pkg::DIV_STAGES + 2;
    localparam int LAST = NSTG - 1;

    logic                 valid_reg [0:LAST];
    logic                 rdy       [0:LAST];
    div3216_pkg::pipe_t   stage_reg  [0:div3216_pkg::DIV_STAGES];
    div3216_pkg::pipe_t   stage_next [0:div3216_pkg::DIV_STAGES];

    logic [div3216_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [div3216_pkg::OUT_USER_W-1:0] out_user_reg, out_user_next;

    // ready chain
    always_comb
    begin
        rdy[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign s_axis_tready = rdy[0];

    // magnitudes and early overflow
    always_comb
    begin
        logic [div3216_pkg::DIVIDEND_W-1:0] num;
        logic [div3216_pkg::DIVISOR_W-1:0]  den;
        logic [div3216_pkg::DIVIDEND_W-1:0] mag_n;
        logic [div3216_pkg::DIVISOR_W-1:0]  mag_d;
        logic                               op;
        logic                               num_neg;
        logic                               den_neg;
        logic                               dbz;
        num     = s_axis_tdata[div3216_pkg::DIVIDEND_W-1:0];
        den     = s_axis_tdata[div3216_pkg::IN_DATA_W-1:div3216_pkg::DIVIDEND_W];
        op      = s_axis_tuser[0];
        num_neg = (op == div3216_pkg::OP_SIGNED) && num[div3216_pkg::DIVIDEND_W-1];
        den_neg = (op == div3216_pkg::OP_SIGNED) && den[div3216_pkg::DIVISOR_W-1];
        mag_n   = num_neg ? (~num + 1'b1) : num;
        mag_d   = den_neg ? (~den + 1'b1) : den;
        dbz     = (den == '0);
        stage_next[0].op      = op;
        stage_next[0].num_neg = num_neg;
        stage_next[0].qneg    = num_neg ^ den_neg;
        stage_next[0].dbz     = dbz;
        stage_next[0].ovf     = !dbz
                                && (mag_n[div3216_pkg::DIVIDEND_W-1:div3216_pkg::QUOT_W] >= mag_d);
        stage_next[0].num     = num;
        stage_next[0].rem     = mag_n[div3216_pkg::DIVIDEND_W-1:div3216_pkg::QUOT_W];
        stage_next[0].low     = mag_n[div3216_pkg::QUOT_W-1:0];
        stage_next[0].den     = mag_d;
    end

    // restoring steps
    for (genvar g = 0; g < div3216_pkg::DIV_STAGES; g++)
    begin : g_div
        div3216_pkg::pipe_t work;
        always_comb
        begin
            work = stage_reg[g];
            for (int k = 0; k < div3216_pkg::STEPS_PER_STAGE; k++)
            begin
                work = div3216_pkg::div_step(work);
            end
        end
        assign stage_next[g+1] = work;
    end

    // sign restore, range check, flags
    always_comb
    begin
        div3216_pkg::pipe_t             p;
        logic                           sovf;
        logic                           ovf;
        logic [div3216_pkg::QUOT_W-1:0] q16;
        logic [div3216_pkg::QUOT_W-1:0] r16;
        p    = stage_reg[div3216_pkg::DIV_STAGES];
        sovf = (p.op == div3216_pkg::OP_SIGNED)
               && (p.qneg ? (p.low > div3216_pkg::QUOT_MAX_NEG)
                          : p.low[div3216_pkg::QUOT_W-1]);
        ovf  = p.ovf || (!p.dbz && sovf);
        q16  = p.qneg ? (~p.low + 1'b1) : p.low;
        r16  = p.num_neg ? (~p.rem + 1'b1) : p.rem;
        if (p.dbz)
        begin
            out_data_next = '0;
            out_user_next = 4'b1000;
        end
        else if (ovf)
        begin
            out_data_next = p.num;
            out_user_next = 4'b0001;
        end
        else
        begin
            out_data_next = {r16, q16};
            out_user_next = {1'b0, (q16 == '0), q16[div3216_pkg::QUOT_W-1], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            stage_reg[0] <= stage_next[0];
        end
        for (int i = 1; i <= div3216_pkg::DIV_STAGES; i++)
        begin
            if (rdy[i] && valid_reg[i-1])
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
        if (rdy[LAST] && valid_reg[LAST-1])
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef NO_ASSERTIONS
    a_dbz_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tdata == '0 && m_axis_tuser[2:0] == '0))
        else $error("divide by zero result not cleared");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0({m_axis_tuser[3], m_axis_tuser[0]}))
        else $error("overflow and divide by zero both set");

    a_ovf_no_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == '0))
        else $error("negative or zero set on overflow");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[3])
        |-> (m_axis_tuser[2] == (m_axis_tdata[15:0] == '0)))
        else $error("zero flag does not match quotient");

    a_neg_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[3])
        |-> (m_axis_tuser[1] == m_axis_tdata[15]))
        else $error("negative flag does not match quotient");
`endif

endmodule

`default_nettype wire
